// ===== hdl/tspem_pkg.sv =====
// Shared types and constants for the TS PID event monitor.
`timescale 1ns / 1ps

package tspem_pkg;

    localparam int PID_W    = 13;
    localparam int SCR_W    = 2;
    localparam int LEN_W    = 8;
    localparam int HEAD_W   = 32;
    localparam int SID_W    = 8;
    localparam int PKT_W    = 48;
    localparam int GAP_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // quotient estimate of pid / PID_COUNT uses this reciprocal scale
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [LEN_W-1:0]  MIN_SCRAMBLE_LEN = 8'd8;
    localparam logic [LEN_W-1:0]  MIN_PES_LEN      = 8'd4;
    localparam logic [23:0]       PES_PREFIX       = 24'h000001;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUSPEND_GAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_CRYPTO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ID_CHG  = 2'd2;

    typedef enum logic [2:0] {
        EV_FIRST       = 3'd0,
        EV_SUSPENDED   = 3'd1,
        EV_RESTARTED   = 3'd2,
        EV_CLR_TO_SCR  = 3'd3,
        EV_SCR_TO_CLR  = 3'd4,
        EV_CRYPTO      = 3'd5,
        EV_FIRST_ID    = 3'd6,
        EV_ID_CHANGE   = 3'd7
    } ev_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } st_t;

    typedef struct packed {
        logic [GAP_W-1:0] suspend_gap;
        logic             report_crypto;
        logic             ignore_id_change;
    } cfg_t;

    // classified packet as it sits in the queue
    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [PID_W-1:0] quo;
        logic [SCR_W-1:0] scr;
        logic             ign_scr;
        logic             pes;
        logic [SID_W-1:0] sid;
    } item_t;

    typedef struct packed {
        ev_t              res;
        logic [PKT_W-1:0] pkt;
        logic [SCR_W-1:0] scr;
        logic [SID_W-1:0] old_id;
        logic [SID_W-1:0] new_id;
    } rec_t;

endpackage

// ===== hdl/tspem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tspem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tspem_front.sv =====
// Input side: takes packet words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module tspem_front #(
    parameter int PID_COUNT = 8192
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tspem_pkg::PID_W-1:0]  pid,
    input  logic [tspem_pkg::SCR_W-1:0]  scramble_bits,
    input  logic                         unit_start,
    input  logic                         payload_present,
    input  logic [tspem_pkg::LEN_W-1:0]  payload_length,
    input  logic [tspem_pkg::HEAD_W-1:0] payload_head,
    input  logic                         clear_done,
    output logic                         q_valid,
    output tspem_pkg::item_t             q_item,
    input  logic                         q_pop
);

    localparam logic [tspem_pkg::RECIP_W-1:0] RECIP = tspem_pkg::RECIP_W'(
        ((64'd1 << tspem_pkg::RECIP_SHIFT) + 64'(PID_COUNT) - 64'd1) / 64'(PID_COUNT));
    localparam int PROD_W = tspem_pkg::PID_W + tspem_pkg::RECIP_W;

    logic [tspem_pkg::LEN_W-1:0] len;
    logic [PROD_W-1:0]           quo_prod;
    tspem_pkg::item_t            item_new;

    tspem_pkg::item_t q_mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;

    always_comb
    begin
        len      = payload_present ? payload_length : '0;
        quo_prod = PROD_W'(pid) * PROD_W'(RECIP);
        item_new.pid     = pid;
        item_new.quo     = quo_prod[tspem_pkg::RECIP_SHIFT +: tspem_pkg::PID_W];
        item_new.scr     = scramble_bits;
        item_new.ign_scr = !payload_present || (len < tspem_pkg::MIN_SCRAMBLE_LEN);
        item_new.pes     = unit_start && (len >= tspem_pkg::MIN_PES_LEN) &&
                           (payload_head[31:8] == tspem_pkg::PES_PREFIX);
        item_new.sid     = payload_head[7:0];
    end

    assign in_ready = (count_reg != 2'd2) && clear_done;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item_new;
        end
    end

endmodule

// ===== hdl/tspem_back.sv =====
// Back end: per-PID record lookup, event evaluation, write-back and result sequencing.
`timescale 1ns / 1ps

module tspem_back #(
    parameter int PID_COUNT   = 8192,
    parameter int INDEX_WIDTH = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tspem_pkg::cfg_t              cfg,
    input  logic                         q_valid,
    input  tspem_pkg::item_t             q_item,
    output logic                         q_pop,
    output logic                         clear_done,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   event_res,
    output logic [tspem_pkg::PID_W-1:0]  event_pid,
    output logic [tspem_pkg::PKT_W-1:0]  event_packet,
    output logic [tspem_pkg::SCR_W-1:0]  event_scramble,
    output logic [tspem_pkg::SID_W-1:0]  old_stream_id,
    output logic [tspem_pkg::SID_W-1:0]  new_stream_id,
    output logic                         last
);

    localparam int SLOT_W = $clog2(PID_COUNT);
    localparam int IW     = INDEX_WIDTH;
    // row: seen, scramble, id valid, stream id, last packet index
    localparam int ROW_W  = IW + 12;
    localparam int SID_LO = IW;
    localparam int IDV_B  = IW + 8;
    localparam int SCR_LO = IW + 9;
    localparam int SEEN_B = IW + 11;
    localparam int CMP_W  = (IW > tspem_pkg::GAP_W) ? IW : tspem_pkg::GAP_W;
    localparam int MUL_W  = 2 * tspem_pkg::PID_W;
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(PID_COUNT - 1);

    tspem_pkg::st_t   state_reg, state_next;
    tspem_pkg::item_t cur_reg, cur_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    logic [IW-1:0]     pkt_idx_reg, pkt_idx_next;
    tspem_pkg::rec_t   rec_reg [3];
    tspem_pkg::rec_t   rec_next [3];
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    tspem_pkg::rec_t   out_rec_reg, out_rec_next;
    logic [tspem_pkg::PID_W-1:0] out_pid_reg, out_pid_next;
    logic              out_last_reg, out_last_next;

    logic [MUL_W-1:0]            slot_prod;
    logic [tspem_pkg::PID_W-1:0] slot_rem;
    logic [SLOT_W-1:0]           head_slot;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  row_rd;
    logic [ROW_W-1:0]  row_wr;

    logic                        seen, id_valid, susp;
    logic [tspem_pkg::SCR_W-1:0] old_scr;
    logic [tspem_pkg::SID_W-1:0] old_sid;
    logic [IW-1:0]               prev_pkt, gap;
    tspem_pkg::rec_t             ev_rec [3];
    tspem_pkg::rec_t             id_rec;
    logic [1:0]                  n_main, ev_cnt;
    logic                        id_ev;

    // pid mod PID_COUNT, quotient estimated in front end
    always_comb
    begin
        slot_prod = MUL_W'(q_item.quo) * MUL_W'(PID_COUNT);
        slot_rem  = q_item.pid - slot_prod[tspem_pkg::PID_W-1:0];
        head_slot = slot_rem[SLOT_W-1:0];
    end

    tspem_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PID_COUNT)
    ) u_rec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_slot),
        .rdata (row_rd)
    );

    // event evaluation for the packet in cur_reg against its stored record
    always_comb
    begin
        seen     = row_rd[SEEN_B];
        id_valid = row_rd[IDV_B];
        old_scr  = row_rd[SCR_LO +: tspem_pkg::SCR_W];
        old_sid  = row_rd[SID_LO +: tspem_pkg::SID_W];
        prev_pkt = row_rd[IW-1:0];
        gap      = pkt_idx_reg - prev_pkt;
        susp     = (cfg.suspend_gap != '0) && (CMP_W'(gap) > CMP_W'(cfg.suspend_gap));

        for (int i = 0; i < 3; i++)
        begin
            ev_rec[i]        = '0;
            ev_rec[i].pkt    = tspem_pkg::PKT_W'(pkt_idx_reg);
            ev_rec[i].scr    = cur_reg.scr;
        end
        n_main = 2'd1;
        if (!seen)
        begin
            ev_rec[0].res = tspem_pkg::EV_FIRST;
        end
        else if (susp)
        begin
            ev_rec[0].res = tspem_pkg::EV_SUSPENDED;
            ev_rec[0].pkt = tspem_pkg::PKT_W'(prev_pkt);
            ev_rec[0].scr = old_scr;
            ev_rec[1].res = tspem_pkg::EV_RESTARTED;
            n_main        = 2'd2;
        end
        else if (!cur_reg.ign_scr && old_scr == '0 && cur_reg.scr != '0)
        begin
            ev_rec[0].res = tspem_pkg::EV_CLR_TO_SCR;
        end
        else if (!cur_reg.ign_scr && old_scr != '0 && cur_reg.scr == '0)
        begin
            ev_rec[0].res = tspem_pkg::EV_SCR_TO_CLR;
        end
        else if (!cur_reg.ign_scr && cfg.report_crypto && old_scr != cur_reg.scr)
        begin
            ev_rec[0].res = tspem_pkg::EV_CRYPTO;
        end
        else
        begin
            n_main = 2'd0;
        end

        id_rec        = '0;
        id_rec.pkt    = tspem_pkg::PKT_W'(pkt_idx_reg);
        id_rec.scr    = cur_reg.scr;
        id_rec.new_id = cur_reg.sid;
        id_ev         = 1'b0;
        if (cur_reg.pes)
        begin
            if (!id_valid)
            begin
                id_rec.res = tspem_pkg::EV_FIRST_ID;
                id_ev      = 1'b1;
            end
            else if (old_sid != cur_reg.sid && !cfg.ignore_id_change)
            begin
                id_rec.res    = tspem_pkg::EV_ID_CHANGE;
                id_rec.old_id = old_sid;
                id_ev         = 1'b1;
            end
        end
        if (id_ev)
        begin
            ev_rec[n_main] = id_rec;
        end
        ev_cnt = n_main + 2'(id_ev);

        row_wr = '0;
        row_wr[SEEN_B]                      = 1'b1;
        row_wr[SCR_LO +: tspem_pkg::SCR_W]  = cur_reg.ign_scr ? old_scr : cur_reg.scr;
        row_wr[IDV_B]                       = id_valid || cur_reg.pes;
        row_wr[SID_LO +: tspem_pkg::SID_W]  = cur_reg.pes ? cur_reg.sid : old_sid;
        row_wr[IW-1:0]                      = pkt_idx_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        pkt_idx_next   = pkt_idx_reg;
        rec_next       = rec_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rec_next   = out_rec_reg;
        out_pid_next   = out_pid_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = row_wr;

        case (state_reg)
            tspem_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SLOT_MAX)
                begin
                    state_next = tspem_pkg::ST_IDLE;
                end
            end
            tspem_pkg::ST_IDLE:
            begin
                // read address is the queue head, so the row is ready next cycle
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    slot_next  = head_slot;
                    state_next = tspem_pkg::ST_EVAL;
                end
            end
            tspem_pkg::ST_EVAL:
            begin
                ram_we       = 1'b1;
                pkt_idx_next = pkt_idx_reg + 1'b1;
                rec_next     = ev_rec;
                cnt_next     = ev_cnt;
                idx_next     = 2'd0;
                state_next   = (ev_cnt == 2'd0) ? tspem_pkg::ST_IDLE : tspem_pkg::ST_EMIT;
            end
            tspem_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rec_next   = rec_reg[idx_reg];
                    out_pid_next   = cur_reg.pid;
                    out_last_next  = (idx_reg == cnt_reg - 2'd1);
                    idx_next       = idx_reg + 2'd1;
                    if (idx_reg == cnt_reg - 2'd1)
                    begin
                        state_next = tspem_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tspem_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tspem_pkg::ST_CLEAR;
            clr_reg       <= '0;
            pkt_idx_reg   <= '0;
            cnt_reg       <= 2'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pkt_idx_reg   <= pkt_idx_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        slot_reg     <= slot_next;
        rec_reg      <= rec_next;
        out_rec_reg  <= out_rec_next;
        out_pid_reg  <= out_pid_next;
        out_last_reg <= out_last_next;
    end

    assign clear_done     = (state_reg != tspem_pkg::ST_CLEAR);
    assign out_valid      = out_valid_reg;
    assign event_res      = out_rec_reg.res;
    assign event_pid      = out_pid_reg;
    assign event_packet   = out_rec_reg.pkt;
    assign event_scramble = out_rec_reg.scr;
    assign old_stream_id  = out_rec_reg.old_id;
    assign new_stream_id  = out_rec_reg.new_id;
    assign last           = out_last_reg;

endmodule

// ===== hdl/ts_pid_event_monitor_unit.sv =====
// Top level of the TS PID event monitor: config registers, front end, back end.
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | pid, scramble_bits, unit_start, payload_*
//  out      | out_valid / out_ready| event_res, event_pid, event_packet, ...
//  cfg      | cfg_write_en         | cfg_index, cfg_data (no read-back)
//
// Each packet passes through the back end in turn: record read, then evaluate and
// write back, then one output word per event (up to three), each held for out_ready;
// the next packet is taken after its last word, if any. A 2-word queue lets input flow
// while events drain. After reset every record RAM row is cleared; in_ready is low then.
// The output register holds a word while out_ready is low; the queue fills behind it.
`timescale 1ns / 1ps

module ts_pid_event_monitor_unit #(
    parameter int PID_COUNT   = 8192,
    parameter int INDEX_WIDTH = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tspem_pkg::PID_W-1:0]      pid,
    input  logic [tspem_pkg::SCR_W-1:0]      scramble_bits,
    input  logic                             unit_start,
    input  logic                             payload_present,
    input  logic [tspem_pkg::LEN_W-1:0]      payload_length,
    input  logic [tspem_pkg::HEAD_W-1:0]     payload_head,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       event_res,
    output logic [tspem_pkg::PID_W-1:0]      event_pid,
    output logic [tspem_pkg::PKT_W-1:0]      event_packet,
    output logic [tspem_pkg::SCR_W-1:0]      event_scramble,
    output logic [tspem_pkg::SID_W-1:0]      old_stream_id,
    output logic [tspem_pkg::SID_W-1:0]      new_stream_id,
    output logic                             last,
    input  logic                             cfg_write_en,
    input  logic [tspem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tspem_pkg::CFG_W-1:0]      cfg_data
);

    tspem_pkg::cfg_t  cfg_reg, cfg_next;
    tspem_pkg::item_t q_item;
    logic             q_valid;
    logic             q_pop;
    logic             clear_done;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                tspem_pkg::REG_SUSPEND_GAP:   cfg_next.suspend_gap      = cfg_data;
                tspem_pkg::REG_REPORT_CRYPTO: cfg_next.report_crypto    = cfg_data[0];
                tspem_pkg::REG_IGNORE_ID_CHG: cfg_next.ignore_id_change = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tspem_front #(
        .PID_COUNT (PID_COUNT)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pid             (pid),
        .scramble_bits   (scramble_bits),
        .unit_start      (unit_start),
        .payload_present (payload_present),
        .payload_length  (payload_length),
        .payload_head    (payload_head),
        .clear_done      (clear_done),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    tspem_back #(
        .PID_COUNT   (PID_COUNT),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .clear_done     (clear_done),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .event_pid      (event_pid),
        .event_packet   (event_packet),
        .event_scramble (event_scramble),
        .old_stream_id  (old_stream_id),
        .new_stream_id  (new_stream_id),
        .last           (last)
    );

    // the back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // the clearing pass runs once after reset only
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        clear_done |=> clear_done)
        else $error("record clear restarted");

    // a suspended word is always followed at once by its restarted word
    a_susp_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && event_res == tspem_pkg::EV_SUSPENDED) |=>
        (out_valid && event_res == tspem_pkg::EV_RESTARTED))
        else $error("suspended word not followed by restarted word");

    a_susp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == tspem_pkg::EV_SUSPENDED) |-> !last)
        else $error("suspended word marked last");

endmodule
